@@ rtl/core/gsr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_pkg
// Shared constants and types for the gamepad shift register emulator.
// ----------------------------------------------------------------------------
package gsr_pkg;

  // Bytes in one frame; each of the two buffers holds this many.
  localparam int FRAME_BYTES = 8;

  localparam int STORE_DEPTH = 2 * FRAME_BYTES;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int CNT_W       = $clog2(FRAME_BYTES + 1);

  localparam logic [STORE_AW-1:0] BUF1_BASE = STORE_AW'(FRAME_BYTES);

  // Action codes.
  localparam logic [1:0] ACT_TICK   = 2'd0;
  localparam logic [1:0] ACT_WRITE  = 2'd1;
  localparam logic [1:0] ACT_COMMIT = 2'd2;

  // Phase codes.
  localparam logic [1:0] PH_IDLE      = 2'd0;
  localparam logic [1:0] PH_WAIT_LOW  = 2'd1;
  localparam logic [1:0] PH_WAIT_HIGH = 2'd2;

  localparam logic [2:0] BIT_LAST = 3'd7;
  localparam logic [7:0] TIMEOUT_RESET = 8'd16;

  typedef struct packed {
    logic [1:0] action;
    logic       latch_level;
    logic       clk_level;
    logic [2:0] byte_index;
    logic [7:0] byte_value;
  } item_t;

  typedef struct packed {
    logic                en;
    logic [STORE_AW-1:0] addr;
    logic [7:0]          data;
  } store_wr_t;

endpackage

@@ rtl/core/gsr_in_reg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_in_reg
// Input register: holds one accepted beat until the core takes it.
// ----------------------------------------------------------------------------
module gsr_in_reg import gsr_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  in_valid,
  output logic  in_ready,
  input  item_t in_item,
  output logic  item_valid,
  output item_t item,
  input  logic  item_take
);

  assign in_ready = !item_valid || item_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (in_ready) begin
      item_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= in_item;
    end
  end

endmodule

@@ rtl/core/gsr_frame_store.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_frame_store
// Double-buffered byte store: one write port, one read port.
// ----------------------------------------------------------------------------
module gsr_frame_store import gsr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  store_wr_t           wr,
  input  logic [STORE_AW-1:0] rd_addr,
  output logic [7:0]          rd_data
);

  logic [7:0] mem [STORE_DEPTH];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STORE_DEPTH; i++) begin
        mem[i] <= 8'd0;
      end
    end else if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  assign rd_data = mem[rd_addr];

endmodule

@@ rtl/core/gsr_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gsr_core
// Shift-out sequencer, buffer selection and the result register.
// ----------------------------------------------------------------------------
module gsr_core import gsr_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  logic                item_valid,
  input  item_t               item,
  output logic                item_take,
  output store_wr_t           store_wr,
  output logic [STORE_AW-1:0] store_rd_addr,
  input  logic [7:0]          store_rd_data,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                data_level,
  output logic                sending,
  output logic                timed_out
);

  logic [7:0]       timeout_ticks;
  logic             fill_select, fill_select_next;
  logic             send_select, send_select_next;
  logic [1:0]       phase, phase_next;
  logic [7:0]       shift_byte, shift_byte_next;
  logic [2:0]       bit_count, bit_count_next;
  logic [CNT_W-1:0] byte_count, byte_count_next;
  logic [7:0]       wait_count, wait_count_next;
  logic             latch_prev, latch_prev_next;
  logic             line_level, line_level_next;
  logic             tout;

  logic             fire;
  logic             start;
  logic [7:0]       drv_byte;
  logic [2:0]       drv_bits;
  logic [CNT_W-1:0] drv_bytes;
  logic [CNT_W-1:0] byte_inc;
  logic             wrap;
  logic [8:0]       miss_count;
  logic             miss_abort;

  assign fire      = item_valid && (!out_valid || out_ready);
  assign item_take = fire;

  // A frame starts on a falling latch edge seen while idle.
  assign start = (phase == PH_IDLE) && latch_prev && !item.latch_level;

  // The first bit of a frame comes straight from the store.
  assign drv_byte  = start ? store_rd_data : shift_byte;
  assign drv_bits  = start ? 3'd0 : bit_count;
  assign drv_bytes = start ? '0 : byte_count;
  assign byte_inc  = drv_bytes + CNT_W'(1);
  assign wrap      = (drv_bits == BIT_LAST);

  always_comb begin
    if (start) begin
      store_rd_addr = fill_select ? '0 : BUF1_BASE;
    end else begin
      store_rd_addr = (send_select ? BUF1_BASE : '0) + STORE_AW'(byte_inc);
    end
  end

  assign miss_count = {1'b0, wait_count} + 9'd1;
  assign miss_abort = (miss_count >= {1'b0, timeout_ticks});

  always_comb begin
    fill_select_next = fill_select;
    send_select_next = send_select;
    phase_next       = phase;
    shift_byte_next  = shift_byte;
    bit_count_next   = bit_count;
    byte_count_next  = byte_count;
    wait_count_next  = wait_count;
    latch_prev_next  = latch_prev;
    line_level_next  = line_level;
    tout             = 1'b0;
    store_wr.en      = 1'b0;
    store_wr.addr    = (fill_select ? BUF1_BASE : '0) + STORE_AW'(item.byte_index);
    store_wr.data    = item.byte_value;

    if (fire) begin
      case (item.action)
        ACT_TICK: begin
          latch_prev_next = item.latch_level;
          if ((phase == PH_WAIT_LOW && !item.clk_level) ||
              (phase == PH_WAIT_HIGH && item.clk_level &&
               32'(byte_count) >= FRAME_BYTES)) begin
            // Awaited level seen with no bit to drive.
            if (phase == PH_WAIT_HIGH) begin
              line_level_next = 1'b0;
              phase_next      = PH_IDLE;
            end else begin
              phase_next = PH_WAIT_HIGH;
            end
            wait_count_next = 8'd0;
          end else if ((phase == PH_WAIT_HIGH && item.clk_level) || start) begin
            if (start) begin
              send_select_next = ~fill_select;
            end
            line_level_next = !drv_byte[7];
            bit_count_next  = drv_bits + 3'd1;
            byte_count_next = wrap ? byte_inc : drv_bytes;
            if (!wrap) begin
              shift_byte_next = {drv_byte[6:0], 1'b0};
            end else if (32'(byte_inc) < FRAME_BYTES) begin
              shift_byte_next = store_rd_data;
            end else begin
              shift_byte_next = 8'd0;
            end
            wait_count_next = 8'd0;
            phase_next      = PH_WAIT_LOW;
          end else if (phase == PH_WAIT_LOW || phase == PH_WAIT_HIGH) begin
            if (miss_abort) begin
              phase_next      = PH_IDLE;
              wait_count_next = 8'd0;
              tout            = 1'b1;
            end else begin
              wait_count_next = miss_count[7:0];
            end
          end
        end
        ACT_WRITE: begin
          store_wr.en = (32'(item.byte_index) < FRAME_BYTES);
        end
        ACT_COMMIT: begin
          fill_select_next = ~fill_select;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks <= TIMEOUT_RESET;
      fill_select   <= 1'b0;
      send_select   <= 1'b0;
      phase         <= PH_IDLE;
      shift_byte    <= 8'd0;
      bit_count     <= 3'd0;
      byte_count    <= '0;
      wait_count    <= 8'd0;
      latch_prev    <= 1'b0;
      line_level    <= 1'b0;
    end else begin
      if (cfg_we) begin
        timeout_ticks <= cfg_data;
      end
      fill_select <= fill_select_next;
      send_select <= send_select_next;
      phase       <= phase_next;
      shift_byte  <= shift_byte_next;
      bit_count   <= bit_count_next;
      byte_count  <= byte_count_next;
      wait_count  <= wait_count_next;
      latch_prev  <= latch_prev_next;
      line_level  <= line_level_next;
    end
  end

  // Result register: holds its beat until the consumer takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      data_level <= line_level_next;
      sending    <= (phase_next != PH_IDLE);
      timed_out  <= tout;
    end
  end

  a_tout_ends_frame: assert property (@(posedge clk) disable iff (rst)
    out_valid && timed_out |-> !sending)
    else $error("timeout reported while a frame is still running");

  a_idle_wait_clear: assert property (@(posedge clk) disable iff (rst)
    phase == PH_IDLE |-> wait_count == 8'd0)
    else $error("wait counter left non-zero in idle");

  a_byte_count_range: assert property (@(posedge clk) disable iff (rst)
    32'(byte_count) <= FRAME_BYTES)
    else $error("byte counter beyond the frame length");

  a_fire_gives_result: assert property (@(posedge clk) disable iff (rst)
    fire |=> out_valid)
    else $error("taken beat produced no result");

endmodule

@@ rtl/core/gamepad_shift_register_emulator.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_shift_register_emulator
// Serial shift-out of a double-buffered controller frame, driven by sampled
// latch and clock pin levels, with a timeout on each clock level wait.
//
// Channel  Handshake            Payload
// in       in_valid/in_ready    action latch_level clk_level byte_index
//                               byte_value
// out      out_valid/out_ready  data_level sending timed_out
// cfg      cfg_we               cfg_data (timeout_ticks)
//
// One beat is taken per cycle while the result is not stalled; the input
// register holds it while the core works on it, and the result register
// loads when the core takes it from the input register.
// Synchronous reset clears the store, the sequencer and both valid flags.
// A stalled result holds; the input register still takes one more beat if empty.
// ----------------------------------------------------------------------------
module gamepad_shift_register_emulator import gsr_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_data,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] action,
  input  logic       latch_level,
  input  logic       clk_level,
  input  logic [2:0] byte_index,
  input  logic [7:0] byte_value,
  output logic       out_valid,
  input  logic       out_ready,
  output logic       data_level,
  output logic       sending,
  output logic       timed_out
);

  item_t               in_item;
  item_t               item;
  logic                item_valid;
  logic                item_take;
  store_wr_t           store_wr;
  logic [STORE_AW-1:0] store_rd_addr;
  logic [7:0]          store_rd_data;

  assign in_item.action      = action;
  assign in_item.latch_level = latch_level;
  assign in_item.clk_level   = clk_level;
  assign in_item.byte_index  = byte_index;
  assign in_item.byte_value  = byte_value;

  gsr_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_item    (in_item),
    .item_valid (item_valid),
    .item       (item),
    .item_take  (item_take)
  );

  gsr_frame_store u_store (
    .clk     (clk),
    .rst     (rst),
    .wr      (store_wr),
    .rd_addr (store_rd_addr),
    .rd_data (store_rd_data)
  );

  gsr_core u_core (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_data      (cfg_data),
    .item_valid    (item_valid),
    .item          (item),
    .item_take     (item_take),
    .store_wr      (store_wr),
    .store_rd_addr (store_rd_addr),
    .store_rd_data (store_rd_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .data_level    (data_level),
    .sending       (sending),
    .timed_out     (timed_out)
  );

endmodule
